// File: src/bfa_pkg.sv
// Shared types and constants for the bitmap frame allocator.
package bfa_pkg;

  // Frame numbers inside the block: a range end can reach 65535 + 65536.
  localparam int FW = 17;
  // Width of the frame index on the ports and of the search cursor.
  localparam int IDX_W = 16;
  // Width of the frame-count register.
  localparam int CFG_W = 17;

  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_RESERVE = 2'd1,
    CMD_FREE    = 2'd2,
    CMD_PEEK    = 2'd3
  } cmd_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_wr;     // write one all-used word of the clearing pass
    logic load;         // capture the accepted beat
    logic div_load;     // split a frame number into word and bit
    logic div_sel_end;  // split the last frame of the range, not the first
    logic store_first;  // keep the first word and bit, issue its read
    logic store_last;   // keep the last word and bit of a range
    logic scan;         // look for a free bit in the word on the read port
    logic mark;         // update the word on the read port for a range
    logic advance;      // step to the next word
    logic finish;       // capture the result
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;   // clearing pass at its last word
    logic empty;        // nothing to search or mark
    logic is_range;     // reserve or free command
    logic hit;          // free frame found in the current word
    logic scan_done;    // current word is the last one below the limit
    logic last_word;    // current word is the last one of the range
  } sts_t;

endpackage

// File: src/bfa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module bfa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: src/bfa_ctrl.sv
// Controller state machine of the bitmap frame allocator.
module bfa_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  bfa_pkg::sts_t sts,
  output bfa_pkg::ctl_t ctl,
  output logic          busy,
  output logic          out_valid
);
  import bfa_pkg::*;

  typedef enum logic [7:0] {
    ST_CLEAR = 8'b0000_0001,
    ST_IDLE  = 8'b0000_0010,
    ST_DIVQ  = 8'b0000_0100,
    ST_DIVR  = 8'b0000_1000,
    ST_ENDQ  = 8'b0001_0000,
    ST_ENDR  = 8'b0010_0000,
    ST_SCAN  = 8'b0100_0000,
    ST_MARK  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   valid_r;

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    unique case (state_r)
      ST_CLEAR: begin
        ctl.clear_wr = 1'b1;
        if (sts.clear_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        ctl.load = start;
        if (start) begin
          state_nxt = ST_DIVQ;
        end
      end
      ST_DIVQ: begin
        ctl.div_load = 1'b1;
        if (sts.empty) begin
          ctl.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end else begin
          state_nxt = ST_DIVR;
        end
      end
      ST_DIVR: begin
        ctl.store_first = 1'b1;
        state_nxt = sts.is_range ? ST_ENDQ : ST_SCAN;
      end
      ST_ENDQ: begin
        ctl.div_load    = 1'b1;
        ctl.div_sel_end = 1'b1;
        state_nxt       = ST_ENDR;
      end
      ST_ENDR: begin
        ctl.store_last = 1'b1;
        state_nxt      = ST_MARK;
      end
      ST_SCAN: begin
        ctl.scan = 1'b1;
        if (sts.hit || sts.scan_done) begin
          ctl.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end else begin
          ctl.advance = 1'b1;
        end
      end
      ST_MARK: begin
        ctl.mark = 1'b1;
        if (sts.last_word) begin
          ctl.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end else begin
          ctl.advance = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= ctl.finish;
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = valid_r;

endmodule

// File: src/bfa_dp.sv
// Datapath of the bitmap frame allocator: operands, word walk, masks, result.
module bfa_dp #(
  parameter int NUM_FRAMES = 65536,
  parameter int WORD_BITS  = 64,
  localparam int MAP_WORDS = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS,
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  bfa_pkg::ctl_t                ctl,
  output bfa_pkg::sts_t                sts,
  input  logic                         cfg_wr_en,
  input  logic [bfa_pkg::CFG_W-1:0]    cfg_wr_data,
  input  logic [1:0]                   in_command,
  input  logic [15:0]                  in_start_frame,
  input  logic [16:0]                  in_frame_count,
  output logic                         ram_we,
  output logic [AW-1:0]                ram_waddr,
  output logic [WORD_BITS-1:0]         ram_wdata,
  output logic [AW-1:0]                ram_raddr,
  input  logic [WORD_BITS-1:0]         ram_rdata,
  output logic [bfa_pkg::IDX_W-1:0]    out_frame_index,
  output logic                         out_found
);
  import bfa_pkg::*;

  localparam int BW        = $clog2(WORD_BITS);
  localparam int LIM_RST   = (NUM_FRAMES < 65536) ? NUM_FRAMES : 65536;
  // Exact division by WORD_BITS for dividends below 2**17.
  localparam int DIV_SHIFT = 23;
  localparam int MW        = 23;
  localparam int DIV_MUL   = ((1 << DIV_SHIFT) + WORD_BITS - 1) / WORD_BITS;
  localparam int PW        = FW + MW;

  cmd_t             cmd_r;
  logic [FW-1:0]    start_r, end_r, lim_r, x_r, q_r, base_r, rem_r;
  logic [IDX_W-1:0] cursor_r, idx_r;
  logic [AW-1:0]    w_r, we_r, clr_r;
  logic [BW-1:0]    b_r, be_r;
  logic             found_r;

  logic                 is_range, alloc_hit, last_word, hit_any;
  logic [FW-1:0]        sum, end_nxt, div_x, div_q, qwb, rem_bits, hit_frame, cfg_lim;
  logic [PW-1:0]        prod;
  logic [AW-1:0]        q_addr;
  logic [BW-1:0]        hit_j;
  logic [WORD_BITS-1:0] lo_ok, lim_ok, free_v, mark_m;

  assign is_range = (cmd_r == CMD_RESERVE) || (cmd_r == CMD_FREE);

  // Clip the range end at the frame limit.
  assign sum     = FW'(in_start_frame) + in_frame_count;
  assign end_nxt = (sum < lim_r) ? sum : lim_r;

  assign cfg_lim = (32'(cfg_wr_data) < 32'(NUM_FRAMES)) ? cfg_wr_data : FW'(NUM_FRAMES);

  // Word and bit of a frame number: reciprocal multiply, then remainder.
  assign div_x  = ctl.div_sel_end ? (end_r - FW'(1)) :
                  (is_range ? start_r : FW'(cursor_r));
  assign prod   = PW'(div_x) * PW'(DIV_MUL);
  assign div_q  = prod[DIV_SHIFT +: FW];
  assign qwb    = q_r * FW'(WORD_BITS);
  assign rem_bits = x_r - qwb;
  assign q_addr = AW'(q_r);

  assign last_word = (w_r == we_r);

  always_comb begin
    for (int j = 0; j < WORD_BITS; j++) begin
      lo_ok[j]  = (BW'(j) >= b_r);
      lim_ok[j] = (FW'(j) < rem_r);
      free_v[j] = ~ram_rdata[j] & lo_ok[j] & lim_ok[j];
      mark_m[j] = lo_ok[j] & (!last_word || (BW'(j) <= be_r));
    end
  end

  // Lowest free bit of the word.
  always_comb begin
    hit_j = '0;
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      if (free_v[j]) begin
        hit_j = BW'(j);
      end
    end
  end

  assign hit_any   = |free_v;
  assign hit_frame = base_r + FW'(hit_j);
  assign alloc_hit = ctl.scan && hit_any && (cmd_r == CMD_ALLOC);

  always_comb begin
    ram_we    = ctl.clear_wr | alloc_hit | ctl.mark;
    ram_waddr = ctl.clear_wr ? clr_r : w_r;
    priority if (ctl.clear_wr) begin
      ram_wdata = '1;
    end else if (ctl.mark) begin
      ram_wdata = (cmd_r == CMD_RESERVE) ? (ram_rdata | mark_m) : (ram_rdata & ~mark_m);
    end else begin
      ram_wdata = ram_rdata | (WORD_BITS'(1) << hit_j);
    end
  end

  always_comb begin
    priority if (ctl.store_first) begin
      ram_raddr = q_addr;
    end else if (ctl.advance) begin
      ram_raddr = w_r + AW'(1);
    end else begin
      ram_raddr = w_r;
    end
  end

  always_comb begin
    sts            = '0;
    sts.clear_last = (clr_r == AW'(MAP_WORDS - 1));
    sts.empty      = is_range ? (start_r >= end_r) : (FW'(cursor_r) >= lim_r);
    sts.is_range   = is_range;
    sts.hit        = hit_any;
    sts.scan_done  = (rem_r <= FW'(WORD_BITS));
    sts.last_word  = last_word;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r    <= FW'(LIM_RST);
      cursor_r <= '0;
      clr_r    <= '0;
    end else begin
      if (cfg_wr_en) begin
        lim_r <= cfg_lim;
      end
      if (ctl.clear_wr) begin
        clr_r <= clr_r + AW'(1);
      end
      if (alloc_hit) begin
        cursor_r <= hit_frame[IDX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r   <= cmd_t'(in_command);
      start_r <= FW'(in_start_frame);
      end_r   <= end_nxt;
    end
    if (ctl.div_load) begin
      x_r <= div_x;
      q_r <= div_q;
    end
    if (ctl.store_first) begin
      w_r    <= q_addr;
      b_r    <= rem_bits[BW-1:0];
      base_r <= qwb;
      rem_r  <= lim_r - qwb;
    end
    if (ctl.store_last) begin
      we_r <= q_addr;
      be_r <= rem_bits[BW-1:0];
    end
    if (ctl.advance) begin
      w_r    <= w_r + AW'(1);
      b_r    <= '0;
      base_r <= base_r + FW'(WORD_BITS);
      rem_r  <= rem_r - FW'(WORD_BITS);
    end
    if (ctl.finish) begin
      found_r <= is_range || (ctl.scan && hit_any);
      idx_r   <= (ctl.scan && hit_any) ? hit_frame[IDX_W-1:0] : '0;
    end
  end

  assign out_frame_index = idx_r;
  assign out_found       = found_r;

endmodule

// File: src/bitmap_frame_allocator.sv
// Top level of the bitmap frame allocator: controller, datapath and bitmap RAM.
//
// One used/free bit per frame, WORD_BITS frames to a RAM word, and a next-fit
// cursor. Pulse start with in_command, in_start_frame and in_frame_count while
// busy is low; the beat is taken on that edge. Exactly one result beat follows
// on out_frame_index and out_found, flagged by out_valid for one cycle. There
// is no backpressure on results: capture them when out_valid is high. Alloc
// and peek search from the cursor toward the frame limit; reserve and free
// update a range clipped at the limit and always report found. The bitmap RAM
// has one read and one write port and the walk handles one word per cycle; a
// search reads from one word up to all words below the limit, and a range
// walks the words it spans. A search with the cursor at or past the limit, or
// an empty range, reads no word. The block can take the next beat in the same
// cycle that its result is shown. After reset a clearing pass marks every
// frame used, one word per cycle over all ceil(NUM_FRAMES / WORD_BITS) words
// (1024 at the defaults); busy stays high through it. cfg_wr_en / cfg_wr_data
// set the frame limit; write it only while busy is low and no beat is in
// flight.
module bitmap_frame_allocator #(
  parameter int NUM_FRAMES = 65536,
  parameter int WORD_BITS  = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_command,
  input  logic [15:0] in_start_frame,
  input  logic [16:0] in_frame_count,
  output logic        out_valid,
  output logic [15:0] out_frame_index,
  output logic        out_found,
  input  logic        cfg_wr_en,
  input  logic [16:0] cfg_wr_data
);
  import bfa_pkg::*;

  localparam int MAP_WORDS = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

  ctl_t                 ctl;
  sts_t                 sts;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [WORD_BITS-1:0] ram_wdata, ram_rdata;

  // Sequence the clearing pass, operand split and word walk.
  bfa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .sts       (sts),
    .ctl       (ctl),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // Hold the operands, cursor and frame limit; build masks and write data.
  bfa_dp #(
    .NUM_FRAMES (NUM_FRAMES),
    .WORD_BITS  (WORD_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctl             (ctl),
    .sts             (sts),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_command      (in_command),
    .in_start_frame  (in_start_frame),
    .in_frame_count  (in_frame_count),
    .ram_we          (ram_we),
    .ram_waddr       (ram_waddr),
    .ram_wdata       (ram_wdata),
    .ram_raddr       (ram_raddr),
    .ram_rdata       (ram_rdata),
    .out_frame_index (out_frame_index),
    .out_found       (out_found)
  );

  // Bitmap store: bit j of word i is frame i*WORD_BITS+j, 1 means used.
  bfa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

`ifndef SYNTHESIS
  // An accepted beat always starts work.
  a_accept_starts_work: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted beat did not raise busy");

  // A result beat lasts a single cycle.
  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  // A result only follows a cycle of work.
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without preceding work");

  // The bitmap is never written while idle.
  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |-> !ram_we)
    else $error("bitmap write while idle");
`endif

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the bitmap frame allocator.
`timescale 1ns / 1ps

module tb_top;
  import bfa_pkg::*;

  localparam int NUM_FRAMES  = 65536;
  localparam int STALL_LIMIT = 20000;  // clearing pass plus a full-map walk, many times over
  localparam int TAIL_CYCLES = 8;
  localparam int NUM_PHASES  = 12;
  localparam int PHASE_BEATS = 72;

  // One reply beat as the block reports it.
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             found;
  } reply_t;

  // One line of the directed sequence: a command beat or a frame-limit write.
  typedef struct packed {
    logic             is_limit;
    cmd_t             cmd;
    logic [IDX_W-1:0] sf;
    logic [CFG_W-1:0] cnt;     // frame count, or the limit value for a write
    logic             typed;   // reply written down here instead of predicted
    logic [IDX_W-1:0] x_idx;
    logic             x_found;
  } row_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  logic [1:0]       in_command = 2'd0;
  logic [15:0]      in_start_frame = 16'd0;
  logic [16:0]      in_frame_count = 17'd0;
  logic             out_valid;
  logic [15:0]      out_frame_index;
  logic             out_found;
  logic             cfg_wr_en = 1'b0;
  logic [16:0]      cfg_wr_data = 17'd0;

  // Shadow of the block: used bit per frame, next-fit cursor, frame limit.
  logic [NUM_FRAMES-1:0] frame_used;
  logic [IDX_W-1:0]      next_fit_cursor;
  logic [CFG_W-1:0]      frame_limit;

  reply_t reply_q [$];
  row_t   dir_rows [$];
  int     mismatches = 0;
  int     idle_cycles = 0;

  always #1 clk = ~clk;

  bitmap_frame_allocator dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_command      (in_command),
    .in_start_frame  (in_start_frame),
    .in_frame_count  (in_frame_count),
    .out_valid       (out_valid),
    .out_frame_index (out_frame_index),
    .out_found       (out_found),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data)
  );

  // Apply one command to the shadow state and return the reply it earns.
  function automatic reply_t allocator_apply(cmd_t cmd, logic [IDX_W-1:0] sf,
                                             logic [CFG_W-1:0] cnt);
    int     lim;
    int     stop;
    int     f;
    reply_t r;
    // A limit above the map size behaves as the map size.
    lim = (int'(frame_limit) > NUM_FRAMES) ? NUM_FRAMES : int'(frame_limit);
    r.idx = '0;
    r.found = 1'b1;
    case (cmd)
      CMD_RESERVE, CMD_FREE: begin
        // Clip the range at the limit; a range starting past it does nothing.
        stop = int'(sf) + int'(cnt);
        if (stop > lim) stop = lim;
        for (f = int'(sf); f < stop; f++) frame_used[f] = (cmd == CMD_RESERVE);
      end
      default: begin
        // Next-fit: scan upward from the cursor, never below it.
        r.found = 1'b0;
        for (f = int'(next_fit_cursor); f < lim && !r.found; f++) begin
          if (!frame_used[f]) begin
            r.found = 1'b1;
            r.idx = f[IDX_W-1:0];
          end
        end
        if (r.found && cmd == CMD_ALLOC) begin
          frame_used[r.idx] = 1'b1;
          next_fit_cursor = r.idx;
        end
      end
    endcase
    return r;
  endfunction

  function automatic row_t beat_row(cmd_t cmd, int sf, int cnt, bit typed = 1'b0,
                                    int xi = 0, bit xf = 1'b0);
    row_t w;
    w = '0;
    w.cmd = cmd;
    w.sf = sf[IDX_W-1:0];
    w.cnt = cnt[CFG_W-1:0];
    w.typed = typed;
    w.x_idx = xi[IDX_W-1:0];
    w.x_found = xf;
    return w;
  endfunction

  function automatic row_t limit_row(int v);
    row_t w;
    w = '0;
    w.is_limit = 1'b1;
    w.cnt = v[CFG_W-1:0];
    return w;
  endfunction

  // Mostly back-to-back or short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Hold a beat on the input until the block takes it, then predict its reply.
  task automatic issue_beat(cmd_t cmd, logic [IDX_W-1:0] sf, logic [CFG_W-1:0] cnt,
                            bit typed, logic [IDX_W-1:0] xi, logic xf);
    reply_t want;
    start <= 1'b1;
    in_command <= cmd;
    in_start_frame <= sf;
    in_frame_count <= cnt;
    @(posedge clk);
    while (busy) @(posedge clk);
    want = allocator_apply(cmd, sf, cnt);
    // Directed rows with a written-down reply still advance the shadow state.
    if (typed) begin
      want.idx = xi;
      want.found = xf;
    end
    reply_q.push_back(want);
  endtask

  // Drop start for a while; wiggle the fields so only start qualifies a beat.
  task automatic idle_gap(int n);
    if (n > 0) begin
      start <= 1'b0;
      in_command <= 2'($urandom_range(0, 3));
      in_start_frame <= 16'($urandom);
      in_frame_count <= 17'($urandom);
      repeat (n) @(posedge clk);
    end
  endtask

  // Hold off new beats until every predicted reply has come back.
  task automatic drain_results();
    start <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk);
  endtask

  // Write the frame limit only with the block idle and nothing in flight.
  task automatic set_frame_limit(logic [CFG_W-1:0] v);
    drain_results();
    while (busy) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    frame_limit = v;
  endtask

  task automatic pace(bit gaps_on);
    if ($urandom_range(0, 99) < 2) drain_results();
    else if (gaps_on) idle_gap(pick_gap());
  endtask

  // Compare every reply beat against the oldest prediction.
  always @(posedge clk) begin
    reply_t want;
    if (rst_n && out_valid) begin
      if (reply_q.size() == 0) begin
        $error("unexpected reply: frame_index %0d found %0d", out_frame_index, out_found);
        mismatches++;
      end else begin
        want = reply_q.pop_front();
        if (out_frame_index !== want.idx) begin
          $error("frame_index mismatch: expected %0d, got %0d", want.idx, out_frame_index);
          mismatches++;
        end
        if (out_found !== want.found) begin
          $error("found mismatch: expected %0d, got %0d", want.found, out_found);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: end the run if no beat moves on either side for too long.
  always @(posedge clk) begin
    if ((start && !busy && rst_n) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  initial begin
    int          p;
    int          k;
    int          base;
    int          lim_eff;
    int          lo;
    int          r;
    int          x;
    int          cfg_val;
    bit          gaps_on;
    cmd_t        cmd;
    logic [15:0] sf;
    logic [16:0] cnt;

    // Shadow state after reset: every frame used, cursor at zero, full limit.
    frame_used = '1;
    next_fit_cursor = '0;
    frame_limit = 17'd65536;

    // Directed sequence, starting from the reset map.
    dir_rows.push_back(beat_row(CMD_PEEK, 0, 0, 1, 0, 0));           // all used: miss
    dir_rows.push_back(beat_row(CMD_ALLOC, 0, 0, 1, 0, 0));
    dir_rows.push_back(beat_row(CMD_FREE, 65535, 1, 1, 0, 1));       // top frame only
    dir_rows.push_back(beat_row(CMD_PEEK, 0, 0, 1, 65535, 1));
    dir_rows.push_back(beat_row(CMD_RESERVE, 65535, 1, 1, 0, 1));
    dir_rows.push_back(beat_row(CMD_FREE, 0, 0, 1, 0, 1));           // empty range
    dir_rows.push_back(beat_row(CMD_FREE, 0, 65536, 1, 0, 1));       // whole map
    dir_rows.push_back(beat_row(CMD_PEEK, 0, 0, 1, 0, 1));
    dir_rows.push_back(beat_row(CMD_ALLOC, 0, 0, 1, 0, 1));
    dir_rows.push_back(beat_row(CMD_ALLOC, 0, 0));
    dir_rows.push_back(beat_row(CMD_FREE, 0, 1, 1, 0, 1));           // below the cursor
    dir_rows.push_back(beat_row(CMD_ALLOC, 0, 0));                   // must skip frame 0
    dir_rows.push_back(beat_row(CMD_RESERVE, 0, 65536, 1, 0, 1));
    dir_rows.push_back(limit_row(131071));                           // above map size
    dir_rows.push_back(beat_row(CMD_FREE, 65000, 65536, 1, 0, 1));   // clipped at limit
    dir_rows.push_back(beat_row(CMD_PEEK, 0, 0));
    dir_rows.push_back(beat_row(CMD_RESERVE, 0, 65536, 1, 0, 1));
    dir_rows.push_back(limit_row(0));
    dir_rows.push_back(beat_row(CMD_FREE, 0, 100, 1, 0, 1));         // wholly past limit
    dir_rows.push_back(beat_row(CMD_PEEK, 0, 0, 1, 0, 0));           // cursor past limit
    dir_rows.push_back(limit_row(64));
    dir_rows.push_back(beat_row(CMD_FREE, 63, 1, 1, 0, 1));
    dir_rows.push_back(beat_row(CMD_PEEK, 0, 0));
    dir_rows.push_back(beat_row(CMD_FREE, 64, 1, 1, 0, 1));          // starts at the limit
    dir_rows.push_back(beat_row(CMD_ALLOC, 0, 0));

    // Hold reset, then wait out the clearing pass.
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);
    while (busy) @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_limit) begin
        set_frame_limit(dir_rows[i].cnt);
      end else begin
        issue_beat(dir_rows[i].cmd, dir_rows[i].sf, dir_rows[i].cnt, dir_rows[i].typed,
                   dir_rows[i].x_idx, dir_rows[i].x_found);
        pace(1'b1);
      end
    end

    // Random phases. The cursor only moves up, so each phase opens a window of
    // frames just ahead of it and caps the limit there to keep searches short.
    for (p = 0; p < NUM_PHASES; p++) begin
      if (p < 10) begin
        base = 64 + p * 6000;
        cfg_val = base + $urandom_range(1, 10) * 64 + $urandom_range(0, 63);
      end else if (p == 10) begin
        base = 64 + p * 6000;
        cfg_val = NUM_FRAMES;
      end else begin
        base = NUM_FRAMES - 16;   // small window so allocs reach the top frame
        cfg_val = 131071;
      end
      gaps_on = (p % 3 != 1);
      set_frame_limit(17'(cfg_val));
      lim_eff = (cfg_val > NUM_FRAMES) ? NUM_FRAMES : cfg_val;

      // Fence off everything between the cursor and the window, then open it.
      if (base > int'(next_fit_cursor)) begin
        issue_beat(CMD_RESERVE, next_fit_cursor, 17'(base - int'(next_fit_cursor)),
                   1'b0, '0, 1'b0);
        pace(gaps_on);
      end
      issue_beat(CMD_FREE, 16'(base), 17'(lim_eff - base), 1'b0, '0, 1'b0);
      pace(gaps_on);

      for (k = 0; k < PHASE_BEATS; k++) begin
        r = $urandom_range(0, 99);
        if (r < 35) cmd = CMD_ALLOC;
        else if (r < 50) cmd = CMD_PEEK;
        else if (r < 80) cmd = CMD_FREE;
        else cmd = CMD_RESERVE;
        r = $urandom_range(0, 99);
        if (r < 6) begin
          // Anywhere in the map, any length.
          sf = 16'($urandom);
          cnt = 17'($urandom_range(0, 65536));
        end else begin
          // Around the window, straddling both edges.
          lo = (base >= 64) ? base - 64 : 0;
          x = lo + $urandom_range(0, lim_eff - lo + 64);
          if (x > 65535) x = 65535;
          sf = 16'(x);
          cnt = (r < 15) ? 17'($urandom_range(0, 65536)) : 17'($urandom_range(0, 48));
        end
        issue_beat(cmd, sf, cnt, 1'b0, '0, 1'b0);
        pace(gaps_on);
      end
    end

    // Let the last replies land, then settle.
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && reply_q.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
